// File: hw/rtl/box_filter_mip_chain_core_defines.svh
// Assertion macros for the box filter mip chain core.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef BOX_FILTER_MIP_CHAIN_CORE_DEFINES_SVH
`define BOX_FILTER_MIP_CHAIN_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BFMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFMC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/bfmc_pkg.sv
// Shared constants and types for the box filter mip chain core.
// No dependencies.
package bfmc_pkg;
  localparam int MaxWidth    = 2048;
  localparam int MaxLevels   = 12;
  localparam int NumChan     = 4;
  localparam int AddrW       = $clog2(MaxWidth);
  localparam int LvlW        = $clog2(MaxLevels);
  localparam int CoordW      = 11;
  localparam int DimW        = 12;
  localparam int PairW       = 9;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegChan   = 2'd2;
  localparam logic [1:0] RegFaces  = 2'd3;

  typedef logic [7:0]       byte_t;
  typedef logic [PairW-1:0] pair_t;
  typedef byte_t [NumChan-1:0] pix_t;
  typedef pair_t [NumChan-1:0] psum_t;

  typedef struct packed {
    logic [2:0]        face;
    logic [LvlW-1:0]   level;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    pix_t              px;
    logic              last;
  } res_t;

  // write / read request to the pair sum memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    psum_t            wdata;
  } mreq_t;
endpackage

// File: hw/rtl/bfmc_sum_ram.sv
// Pair sum memory: one write or read per cycle, registered read data.
// Depends on bfmc_pkg.
module bfmc_sum_ram (
  input  logic           clk,
  input  bfmc_pkg::mreq_t req,
  input  logic           re,
  output bfmc_pkg::psum_t rdata
);
  import bfmc_pkg::*;
  psum_t mem [MaxWidth];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    if (re) rdata <= mem[req.addr];
  end
endmodule

// File: hw/rtl/box_filter_mip_chain_core.sv
// Top level of the box filter mip chain core: level walker, output register.
// Depends on bfmc_pkg, bfmc_sum_ram and the defines header.
//
// channel | direction | beat content
// in_     | slave     | tdata: chan0..chan3
// out_    | master    | tdata: face,level,x,y,out0..3 (61b pad 64); tlast: run_last
// cfg_    | write     | index 2 bits, data 12 bits
//
// A pixel is accepted in S_IDLE, visits each level in S_LVL, passes S_SUM for
// each coarser result it completes (memory read latency) and S_DONE to release
// the last result. in_tready only in idle. A result waiting on out_tready
// stalls the walker; the level 0 result waits in a pending register. rst_n is
// synchronous; a config write restarts the stream.
`include "box_filter_mip_chain_core_defines.svh"
module box_filter_mip_chain_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // chan0, chan1, chan2, chan3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // face3,level4,x11,y11,out0..3 (61b pad 64)
  output logic        out_tlast,  // run_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import bfmc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LVL, S_SUM, S_DONE} st_t;

  logic [DimW-1:0] bw_r, bh_r;
  logic [2:0]      nch_r, fc_r;
  st_t             st_r;
  logic [CoordW-1:0] col_r [MaxLevels];
  logic [CoordW-1:0] row_r [MaxLevels];
  pix_t            hold_r [MaxLevels];
  logic [2:0]      face_r;
  logic [LvlW-1:0] l_r;
  logic [DimW-1:0] pw_r, ph_r;
  logic [AddrW-1:0] off_r;
  pix_t            cur_r;
  psum_t           pair_r;
  res_t            pend_r;
  logic            ovld_r;
  res_t            ores_r;

  logic [DimW-1:0] cw, chh, tw, th;
  logic [2:0]      nch, fce, face_nxt;
  logic            lastlvl;
  logic [LvlW-1:0] nl;
  logic [CoordW-1:0] x, y;
  logic [DimW-1:0] xe, ye, tw2, th2;
  logic [AddrW-1:0] slot;
  logic            hskip, hhold, vpair, go_sum, col_wrap, row_wrap;
  psum_t           pair, rdata;
  pix_t            avg, inpx;
  logic [10:0]     qs [NumChan];
  res_t            emit_res;
  mreq_t           mreq;
  logic            re;
  logic            stall, emit, ovld_nxt, face_done;

  always_comb begin
    cw = (bw_r == '0) ? DimW'(1) : (bw_r > DimW'(MaxWidth) ? DimW'(MaxWidth) : bw_r);
    chh = (bh_r == '0) ? DimW'(1) : (bh_r > DimW'(MaxWidth) ? DimW'(MaxWidth) : bh_r);
    nch = (nch_r == 3'd0) ? 3'd1 : ((nch_r > 3'd4) ? 3'd4 : nch_r);
    fce = (fc_r == 3'd0) ? 3'd1 : ((fc_r > 3'd6) ? 3'd6 : fc_r);
  end

  assign face_nxt = ((face_r + 3'd1) >= fce) ? 3'd0 : face_r + 3'd1;
  assign tw = (pw_r > DimW'(1)) ? (pw_r >> 1) : DimW'(1);
  assign th = (ph_r > DimW'(1)) ? (ph_r >> 1) : DimW'(1);
  assign tw2 = {tw[CoordW-1:0], 1'b0};
  assign th2 = {th[CoordW-1:0], 1'b0};
  assign lastlvl = ((pw_r == DimW'(1)) && (ph_r == DimW'(1))) ||
                   (l_r == LvlW'(MaxLevels - 1));
  assign nl = l_r + LvlW'(1);
  assign x = col_r[l_r];
  assign y = row_r[l_r];
  assign xe = {1'b0, x};
  assign ye = {1'b0, y};
  assign slot = off_r + (x >> 1);

  // odd last column dropped, even column held for its right neighbor
  assign hskip = (pw_r != DimW'(1)) && ((xe >= tw2) || !x[0]);
  assign hhold = (pw_r != DimW'(1)) && (xe < tw2) && !x[0];
  assign vpair = (ph_r != DimW'(1)) && (ye < th2);
  assign go_sum = !lastlvl && !hskip && ((ph_r == DimW'(1)) || (vpair && y[0]));
  assign col_wrap = (xe + DimW'(1)) >= pw_r;
  assign row_wrap = (ye + DimW'(1)) >= ph_r;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      inpx[c] = (3'(c) < nch) ? in_tdata[8*c +: 8] : 8'd0;
      if (pw_r == DimW'(1)) pair[c] = {cur_r[c], 1'b0};
      else pair[c] = PairW'(hold_r[l_r][c]) + PairW'(cur_r[c]);
    end
  end

  // sum of quad and rounding; vertical size 1 doubles the pair
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (ph_r == DimW'(1)) qs[c] = {1'b0, pair_r[c], 1'b0};
      else qs[c] = 11'(rdata[c]) + 11'(pair_r[c]);
      avg[c] = 8'((qs[c] + 11'd2) >> 2);
    end
  end

  assign stall = ovld_r && !out_tready;
  assign emit = ((st_r == S_SUM) || (st_r == S_DONE)) && !stall && !cfg_we;
  assign ovld_nxt = emit || stall;
  assign in_tready = (st_r == S_IDLE);
  assign face_done = (col_r[0] == '0) && (row_r[0] == '0);

  always_comb begin
    emit_res = pend_r;
    emit_res.last = (st_r == S_DONE);
  end

  always_comb begin
    mreq.addr = slot;
    mreq.wdata = pair;
    mreq.we = (st_r == S_LVL) && !lastlvl && !hskip && vpair && !y[0];
    re = (st_r == S_LVL) && go_sum && (ph_r != DimW'(1));
  end

  bfmc_sum_ram u_ram (.clk(clk), .req(mreq), .re(re), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovld_r <= 1'b0; face_r <= '0;
      bw_r <= DimW'(1); bh_r <= DimW'(1); nch_r <= 3'd4; fc_r <= 3'd1;
      for (int i = 0; i < MaxLevels; i++) begin col_r[i] <= '0; row_r[i] <= '0; end
    end else begin
      ovld_r <= ovld_nxt;
      if (emit) ores_r <= emit_res;
      if (cfg_we) begin
        unique case (cfg_index)
          RegWidth:  bw_r <= cfg_data;
          RegHeight: bh_r <= cfg_data;
          RegChan:   nch_r <= cfg_data[2:0];
          RegFaces:  fc_r <= cfg_data[2:0];
          default: ;
        endcase
        face_r <= '0;
        for (int i = 0; i < MaxLevels; i++) begin col_r[i] <= '0; row_r[i] <= '0; end
      end else begin
        unique case (st_r)
          S_IDLE: if (in_tvalid) begin
            cur_r <= inpx;
            pend_r <= '{face: face_r, level: '0, x: col_r[0], y: row_r[0], px: inpx,
                        last: 1'b0};
            l_r <= '0; pw_r <= cw; ph_r <= chh; off_r <= '0;
            st_r <= S_LVL;
          end
          S_LVL: begin
            // advance this level's position
            if (col_wrap) begin
              col_r[l_r] <= '0;
              row_r[l_r] <= row_wrap ? '0 : y + CoordW'(1);
            end else col_r[l_r] <= x + CoordW'(1);
            if (!lastlvl && hhold) hold_r[l_r] <= cur_r;
            pair_r <= pair;
            st_r <= go_sum ? S_SUM : S_DONE;
          end
          S_SUM: if (!stall) begin
            cur_r <= avg;
            pend_r <= '{face: face_r, level: nl, x: col_r[nl], y: row_r[nl], px: avg,
                        last: 1'b0};
            off_r <= off_r + AddrW'(tw);
            l_r <= nl; pw_r <= tw; ph_r <= th;
            st_r <= S_LVL;
          end
          S_DONE: if (!stall) begin
            if (face_done) begin
              face_r <= face_nxt;
              for (int i = 0; i < MaxLevels; i++) begin col_r[i] <= '0; row_r[i] <= '0; end
            end
            st_r <= S_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {3'd0, ores_r.px[3], ores_r.px[2], ores_r.px[1], ores_r.px[0],
                      ores_r.y, ores_r.x, ores_r.level, ores_r.face};
  assign out_tlast = ores_r.last;

  `BFMC_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_tready, st_r == S_IDLE)
  `BFMC_ASSERT_IMP(a_lvl_ok, clk, rst_n, st_r != S_IDLE, l_r < LvlW'(MaxLevels))
  `BFMC_ASSERT_IMP(a_mem_one, clk, rst_n, mreq.we, !re)
  `BFMC_ASSERT_NXT(a_hold_out, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `BFMC_ASSERT_NXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
endmodule
